// ----- rtl/plst_pkg.sv -----
// Shared types and codes for the positional list store.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps
`default_nettype none

package plst_pkg;

    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_APPEND    = 3'd1,
        OP_READ      = 3'd2,
        OP_INSERT    = 3'd3,
        OP_OVERWRITE = 3'd4,
        OP_DELETE    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Per-cycle command broadcast from the controller to every cell.
    typedef struct packed {
        logic write;      // the cell at the target takes the new word
        logic shift_up;   // cells above the target take their lower neighbor
        logic shift_down; // cells from the target up take their upper neighbor
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/plst_cell.sv -----
// One storage cell of the list: holds a single entry.
// Depends on plst_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module plst_cell #(
    parameter int WORD_BITS = 32,
    parameter int CMP_W     = 8,
    parameter int INDEX     = 0
) (
    input  wire logic                 clk,
    input  wire plst_pkg::cmd_t       cmd,
    input  wire logic [CMP_W-1:0]     target,
    input  wire logic [CMP_W-1:0]     count,
    input  wire logic [WORD_BITS-1:0] value_w,
    input  wire logic [WORD_BITS-1:0] left_word,
    input  wire logic [WORD_BITS-1:0] right_word,
    output logic      [WORD_BITS-1:0] word,
    output logic      [WORD_BITS-1:0] tap
);

    localparam logic [CMP_W-1:0] IDX  = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX1 = CMP_W'(INDEX + 1);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        priority if (cmd.write && (IDX == target))
        begin
            word_next = value_w;
        end
        else if (cmd.shift_up && (IDX > target) && (IDX <= count))
        begin
            word_next = left_word;
        end
        else if (cmd.shift_down && (IDX >= target) && (IDX1 < count))
        begin
            word_next = right_word;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    // Only the addressed cell puts its entry on the shared read bus.
    assign tap  = (IDX == target) ? word_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/plst_ctrl.sv -----
// Controller: fill count register, request checks and cell commands.
// Depends on plst_pkg for opcodes, status codes and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module plst_ctrl #(
    parameter int CAPACITY = 128,
    parameter int CMP_W    = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [2:0]          opcode,
    input  wire logic [6:0]          position,
    output plst_pkg::cmd_t           cmd,
    output logic      [CMP_W-1:0]    target,
    output logic      [CMP_W-1:0]    count,
    output logic      [CMP_W-1:0]    count_next,
    output plst_pkg::status_t        status,
    output logic                     rd_en
);

    localparam logic [CMP_W-1:0] CAP = CMP_W'(CAPACITY);

    logic [CMP_W-1:0] count_reg;
    logic [CMP_W-1:0] pos;
    logic             full;
    logic             empty;

    assign pos   = CMP_W'(position);
    assign full  = (count_reg == CAP);
    assign empty = (count_reg == '0);
    assign count = count_reg;

    always_comb
    begin
        cmd        = '0;
        target     = pos;
        count_next = count_reg;
        status     = plst_pkg::ST_OK;
        rd_en      = 1'b0;
        unique case (plst_pkg::op_t'(opcode))
            plst_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            plst_pkg::OP_APPEND:
            begin
                target = count_reg;
                if (full)
                begin
                    status = plst_pkg::ST_FULL;
                end
                else
                begin
                    cmd.write  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            plst_pkg::OP_INSERT:
            begin
                priority if (full)
                begin
                    status = plst_pkg::ST_FULL;
                end
                else if (pos > count_reg)
                begin
                    status = plst_pkg::ST_RANGE;
                end
                else
                begin
                    cmd.write    = 1'b1;
                    cmd.shift_up = 1'b1;
                    count_next   = count_reg + 1'b1;
                end
            end
            plst_pkg::OP_READ, plst_pkg::OP_OVERWRITE, plst_pkg::OP_DELETE:
            begin
                priority if (empty)
                begin
                    status = plst_pkg::ST_EMPTY;
                end
                else if (pos >= count_reg)
                begin
                    status = plst_pkg::ST_RANGE;
                end
                else if (plst_pkg::op_t'(opcode) == plst_pkg::OP_OVERWRITE)
                begin
                    cmd.write = 1'b1;
                end
                else if (plst_pkg::op_t'(opcode) == plst_pkg::OP_DELETE)
                begin
                    rd_en          = 1'b1;
                    cmd.shift_down = 1'b1;
                    count_next     = count_reg - 1'b1;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                // Unused opcodes leave the list alone and report success.
            end
        endcase
        if (!accept)
        begin
            cmd        = '0;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/positional_list_store_top.sv -----
// Top level of the positional list store: controller plus a row of cells.
// Depends on plst_pkg, plst_ctrl and plst_cell.
// The result word is registered and appears with done in the cycle after start is taken.
// Throughput: one request per cycle; every cell updates in the same cycle.
// Reset clears the fill count and the done strobe; entries stay undefined
// until written. The receiver cannot stall, so busy never rises.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store_top #(
    parameter int CAPACITY  = 128,
    parameter int WORD_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         opcode,
    input  wire logic [6:0]         position,
    input  wire logic signed [31:0] value,
    output logic                    done,
    output logic signed [31:0]      read_value,
    output logic [7:0]              fill_count,
    output logic [1:0]              status
);

    // Positions and counts are compared at a width that holds both the
    // seven-bit position field and the full count up to CAPACITY.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    logic                        accept;
    plst_pkg::cmd_t              cmd;
    logic [CMP_W-1:0]            target;
    logic [CMP_W-1:0]            count;
    logic [CMP_W-1:0]            count_next;
    plst_pkg::status_t           status_c;
    logic                        rd_en;

    logic signed [WORD_BITS-1:0] value_w;
    logic [WORD_BITS-1:0]        words [CAPACITY];
    logic [WORD_BITS-1:0]        taps  [CAPACITY];
    logic signed [WORD_BITS-1:0] rd_word;

    logic                        done_reg;
    logic signed [31:0]          read_value_reg;
    logic signed [31:0]          read_value_next;
    logic [7:0]                  fill_count_reg;
    logic [1:0]                  status_reg;

    // No request ever holds the block, so a new word is always welcome.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Incoming words are resized to the storage width with sign extension.
    assign value_w = WORD_BITS'(value);

    plst_ctrl #(
        .CAPACITY (CAPACITY),
        .CMP_W    (CMP_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .position   (position),
        .cmd        (cmd),
        .target     (target),
        .count      (count),
        .count_next (count_next),
        .status     (status_c),
        .rd_en      (rd_en)
    );

    // The row of cells. Each cell sees its two neighbors so that an insert
    // moves every later entry up and a delete moves them down, all at once.
    // The end cells get zero from the missing side; that path is never
    // selected because the count guards keep it out of range.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_word;
        logic [WORD_BITS-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_left
            assign left_word = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_right
            assign right_word = words[i+1];
        end

        plst_cell #(
            .WORD_BITS (WORD_BITS),
            .CMP_W     (CMP_W),
            .INDEX     (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .target     (target),
            .count      (count),
            .value_w    (value_w),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i]),
            .tap        (taps[i])
        );
    end

    // Only the cell at the target drives a non-zero tap, so an OR over the
    // row yields the addressed entry before any shift takes effect.
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | taps[i];
        end
    end

    // Read and delete return the old entry, sign-extended to 32 bits.
    assign read_value_next = rd_en ? 32'(rd_word) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
            fill_count_reg <= 8'(count_next);
            status_reg     <= status_c;
        end
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign fill_count = fill_count_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_done_follows_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> done
    ) else $error("done missing after an accepted request");

    a_no_spurious_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        !accept |=> !done
    ) else $error("done without an accepted request");

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        count <= CMP_W'(CAPACITY)
    ) else $error("fill count exceeds capacity");

    a_error_keeps_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept && (status_c != plst_pkg::ST_OK) |=> count == $past(count)
    ) else $error("failed request changed the fill count");

    a_error_reads_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        done && (status != plst_pkg::ST_OK) |-> read_value == '0
    ) else $error("failed request returned a non-zero word");
`endif

endmodule

`default_nettype wire
